>>> rtl/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants, codes and control types of the streaming FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 15;
  localparam int TAP_W       = 7;
  localparam int FUNC_W      = 2;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = $clog2(MAX_TAPS + 1);
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS) + 1;

  localparam logic [TAP_W-1:0] TAP_COUNT_RESET = TAP_W'(64);

  localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COEF   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic push;
    logic rotate;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sat;
  } mac_res_t;

endpackage

>>> rtl/fir_in_if.sv
// ----------------------------------------------------------------------------
// fir_in_if
// Input channel of the FIR filter: valid/ready handshake and item payload.
// ----------------------------------------------------------------------------
interface fir_in_if;
  import fir_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [FUNC_W-1:0]             func;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [IDX_W-1:0]              coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;

  modport source (output valid, func, in_sample, coef_index, coef_value, input ready);
  modport sink   (input valid, func, in_sample, coef_index, coef_value, output ready);

endinterface

>>> rtl/fir_out_if.sv
// ----------------------------------------------------------------------------
// fir_out_if
// Output channel of the FIR filter: valid/ready handshake and result payload.
// ----------------------------------------------------------------------------
interface fir_out_if;
  import fir_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          saturated;

  modport source (output valid, out_sample, saturated, input ready);
  modport sink   (input valid, out_sample, saturated, output ready);

endinterface

>>> rtl/fir_cell.sv
// ----------------------------------------------------------------------------
// fir_cell
// One tap cell: holds a history sample and a coefficient, shifts samples
// toward older taps on a push and rotates both toward the head on a step.
// ----------------------------------------------------------------------------
module fir_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fir_pkg::cell_ctrl_t                    ctrl_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] x_prev_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] x_next_i,
  input  logic signed [fir_pkg::COEF_BITS-1:0]   h_next_i,
  input  logic                                   coef_we_i,
  input  logic signed [fir_pkg::COEF_BITS-1:0]   coef_wdata_i,
  output logic signed [fir_pkg::SAMPLE_BITS-1:0] x_o,
  output logic signed [fir_pkg::COEF_BITS-1:0]   h_o
);
  import fir_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic signed [COEF_BITS-1:0]   h_q, h_d;

  always_comb begin
    x_d = x_q;
    h_d = h_q;
    if (ctrl_i.clear) begin
      x_d = '0;
    end else if (ctrl_i.push) begin
      x_d = x_prev_i;
    end else if (ctrl_i.rotate) begin
      x_d = x_next_i;
    end
    if (coef_we_i) begin
      h_d = coef_wdata_i;
    end else if (ctrl_i.rotate) begin
      h_d = h_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      h_q <= '0;
    end else begin
      x_q <= x_d;
      h_q <= h_d;
    end
  end

  assign x_o = x_q;
  assign h_o = h_q;

endmodule

>>> rtl/fir_mac.sv
// ----------------------------------------------------------------------------
// fir_mac
// Multiply-accumulate at the head of the tap chain, with round half up and
// saturation of the finished sum.
// ----------------------------------------------------------------------------
module fir_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fir_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] x_i,
  input  logic signed [fir_pkg::COEF_BITS-1:0]   h_i,
  output fir_pkg::mac_res_t                      res_o
);
  import fir_pkg::*;

  localparam int QW = ACC_W - COEF_FRAC;
  localparam logic signed [QW-1:0] Q_MAX = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     prod_v_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [QW-1:0]     q;

  assign prod_d   = x_i * h_i;
  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + prod_ext;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.mul_en;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor((acc + half) / 2^frac), then clip
  assign rnd = acc_q + HALF;
  assign q   = rnd[ACC_W-1:COEF_FRAC];

  always_comb begin
    if (q > Q_MAX) begin
      res_o.sample = Q_MAX[SAMPLE_BITS-1:0];
      res_o.sat    = 1'b1;
    end else if (q < Q_MIN) begin
      res_o.sample = Q_MIN[SAMPLE_BITS-1:0];
      res_o.sat    = 1'b1;
    end else begin
      res_o.sample = q[SAMPLE_BITS-1:0];
      res_o.sat    = 1'b0;
    end
  end

endmodule

>>> rtl/fir_filter_stream_core.sv
// ----------------------------------------------------------------------------
// fir_filter_stream_core
// Streaming direct-form FIR filter built as a chain of tap cells.
// ----------------------------------------------------------------------------
// A filter item (func 0) pushes its sample into the chain, and its result is
// offered after the RUN, DRAIN and FIN states. The chain rotates once per
// cycle in RUN past the single multiply-accumulate unit at its head, so every
// tap slot is visited in turn whatever tap_count holds. Then the sum is
// rounded and registered. The input is ready again in the cycle after that, so
// no new filter item is accepted before the last one's result is registered. A
// result still waiting on the output holds the next one back until it leaves.
// Coefficient writes (func 1), history clears (func 2) and ignored items
// (func 3) are taken in the idle state and give no result. The input is ready
// whenever no filter item is in progress, also while a result still waits on
// the output. tap_count may be written only while the block is idle;
// coefficient writes apply at once to every sample held in the history.
// ----------------------------------------------------------------------------
module fir_filter_stream_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fir_pkg::TAP_W-1:0] cfg_wdata_i,
  fir_in_if.sink                    in_s,
  fir_out_if.source                 out_m
);
  import fir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e                        state_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [TAP_W-1:0]              tap_count_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_sat_q;

  logic                          in_xfer;
  logic [CNT_W-1:0]              taps;
  cell_ctrl_t                    cell_ctrl;
  mac_ctrl_t                     mac_ctrl;
  mac_res_t                      mac_res;
  logic                          load_out;

  logic signed [SAMPLE_BITS-1:0] x_chain [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   h_chain [MAX_TAPS];

  assign in_s.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_s.valid && in_s.ready;

  assign taps = (int'(tap_count_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count_q);

  always_comb begin
    cell_ctrl.push   = in_xfer && (in_s.func == FUNC_FILTER);
    cell_ctrl.clear  = in_xfer && (in_s.func == FUNC_CLEAR);
    cell_ctrl.rotate = (state_q == ST_RUN);
    mac_ctrl.clr     = cell_ctrl.push;
    mac_ctrl.mul_en  = (state_q == ST_RUN) && (cnt_q < taps);
  end

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] x_prev;
    logic signed [SAMPLE_BITS-1:0] x_next;
    logic signed [COEF_BITS-1:0]   h_next;
    logic                          we;

    if (i == 0) begin : g_head
      assign x_prev = in_s.in_sample;
    end else begin : g_body
      assign x_prev = x_chain[i-1];
    end

    if (i == MAX_TAPS - 1) begin : g_tail
      assign x_next = x_chain[0];
      assign h_next = h_chain[0];
    end else begin : g_inner
      assign x_next = x_chain[i+1];
      assign h_next = h_chain[i+1];
    end

    assign we = in_xfer && (in_s.func == FUNC_COEF) && (int'(in_s.coef_index) == i);

    fir_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .x_prev_i     (x_prev),
      .x_next_i     (x_next),
      .h_next_i     (h_next),
      .coef_we_i    (we),
      .coef_wdata_i (in_s.coef_value),
      .x_o          (x_chain[i]),
      .h_o          (h_chain[i])
    );
  end

  fir_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (x_chain[0]),
    .h_i    (h_chain[0]),
    .res_o  (mac_res)
  );

  assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_m.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tap_count_q <= TAP_COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
      if (out_m.valid && out_m.ready && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (cell_ctrl.push) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_q == CNT_W'(MAX_TAPS - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_sample_q <= mac_res.sample;
      out_sat_q    <= mac_res.sat;
    end
  end

  assign out_m.valid      = out_valid_q;
  assign out_m.out_sample = out_sample_q;
  assign out_m.saturated  = out_sat_q;

endmodule

>>> tb/tb_fir_filter_stream_core.sv
// ----------------------------------------------------------------------------
// tb_fir_filter_stream_core
// Self-checking bench for the streaming FIR filter. Filter, coefficient,
// clear and ignored items are pushed through the input channel with random
// gaps while the output channel stalls at random. A software copy of the
// coefficient and history stores predicts each rounded, saturated output,
// which is checked field by field in order of arrival. tap_count is
// reprogrammed between phases, including zero and values beyond the tap store.
// ----------------------------------------------------------------------------
module tb_fir_filter_stream_core;
  import fir_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
  localparam int IDLE_PAUSE  = MAX_TAPS + 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_PHASES    = 13;
  localparam int PHASE_ITEMS = 41;

  class fir_output_checker;
    logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] history  [MAX_TAPS];
    logic [TAP_W-1:0]              tap_count;
    mac_res_t                      pending_outputs [$];
    int                            n_errors;

    function new();
      tap_count = TAP_COUNT_RESET;
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (history[i]) history[i] = '0;
      n_errors = 0;
    endfunction

    function void set_tap_count(logic [TAP_W-1:0] value);
      tap_count = value;
    endfunction

    function mac_res_t filter_response();
      longint   acc;
      longint   q;
      longint   max_val;
      int       taps;
      mac_res_t res;
      max_val = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      taps    = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
      acc     = 0;
      for (int k = 0; k < taps; k++) begin
        acc += longint'(history[k]) * longint'(coef_mem[k]);
      end
      // round half up, then floor
      q       = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      res.sat = 1'b0;
      if (q > max_val) begin
        q       = max_val;
        res.sat = 1'b1;
      end else if (q < -max_val - 1) begin
        q       = -max_val - 1;
        res.sat = 1'b1;
      end
      res.sample = q[SAMPLE_BITS-1:0];
      return res;
    endfunction

    function void note_item(logic [FUNC_W-1:0] func, logic signed [SAMPLE_BITS-1:0] smp,
                            logic [IDX_W-1:0] idx, logic signed [COEF_BITS-1:0] cval);
      case (func)
        FUNC_FILTER: begin
          for (int k = MAX_TAPS - 1; k > 0; k--) history[k] = history[k-1];
          history[0] = smp;
          pending_outputs.push_back(filter_response());
        end
        FUNC_COEF: begin
          if (idx < MAX_TAPS) coef_mem[idx] = cval;
        end
        FUNC_CLEAR: begin
          foreach (history[i]) history[i] = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic signed [SAMPLE_BITS-1:0] smp, logic sat);
      mac_res_t exp_res;
      if (pending_outputs.size() == 0) begin
        $error("out_sample: no result expected, got %0d (saturated %0b)", smp, sat);
        n_errors++;
        return;
      end
      exp_res = pending_outputs.pop_front();
      if (smp !== exp_res.sample) begin
        $error("out_sample: expected %0d, actual %0d", exp_res.sample, smp);
        n_errors++;
      end
      if (sat !== exp_res.sat) begin
        $error("saturated: expected %0b, actual %0b", exp_res.sat, sat);
        n_errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TAP_W-1:0] cfg_wdata_i;
  bit               sender_idle;
  bit               stall_on;
  int               cycle_count;

  fir_in_if  in_if ();
  fir_out_if out_if ();

  fir_output_checker out_checker = new();

  fir_filter_stream_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_s        (in_if),
    .out_m       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // transfer monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        out_checker.note_item(in_if.func, in_if.in_sample, in_if.coef_index,
                              in_if.coef_value);
      end
      if (out_if.valid && out_if.ready) begin
        out_checker.check_output(out_if.out_sample, out_if.saturated);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2:       return SAMPLE_BITS'($urandom_range(0, 64) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(COEF_BITS-1){1'b0}}};
      1:       return {1'b0, {(COEF_BITS-1){1'b1}}};
      2, 3, 4: return COEF_BITS'($urandom_range(0, 4096) - 2048);
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [TAP_W-1:0] pick_tap_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TAP_W'(1);
      2:       return TAP_W'(MAX_TAPS);
      3:       return '1;
      4:       return TAP_W'($urandom_range(MAX_TAPS + 1, 2 ** TAP_W - 1));
      default: return TAP_W'($urandom_range(2, MAX_TAPS - 1));
    endcase
  endfunction

  // output stalls, off for whole phases at times
  initial begin
    int hold;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = stall_on ? pick_gap() : 0;
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] func,
                           input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic [IDX_W-1:0] idx,
                           input logic signed [COEF_BITS-1:0] cval);
    int gap;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= func;
    in_if.in_sample  <= smp;
    in_if.coef_index <= idx;
    in_if.coef_value <= cval;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_filter(input logic signed [SAMPLE_BITS-1:0] smp);
    send_item(FUNC_FILTER, smp, IDX_W'($urandom), pick_coef());
  endtask

  task automatic send_coef(input logic [IDX_W-1:0] idx, input logic signed [COEF_BITS-1:0] cval);
    send_item(FUNC_COEF, pick_sample(), idx, cval);
  endtask

  task automatic send_clear();
    send_item(FUNC_CLEAR, pick_sample(), IDX_W'($urandom), pick_coef());
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (out_checker.pending_outputs.size() != 0);
  endtask

  task automatic write_tap_count(input logic [TAP_W-1:0] value);
    wait_drain();
    repeat (IDLE_PAUSE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    out_checker.set_tap_count(value);
  endtask

  initial begin
    logic [TAP_W-1:0] taps;
    int               live;
    int               r;
    cycle_count      <= 0;
    sender_idle      <= 1'b1;
    stall_on         <= 1'b1;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_if.valid      <= 1'b0;
    in_if.func       <= FUNC_FILTER;
    in_if.in_sample  <= '0;
    in_if.coef_index <= '0;
    in_if.coef_value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, saturation both ways, rounding ties, ignored func
    send_filter(16'sh7fff);
    send_coef(6'd0, 16'sh7fff);
    send_coef(6'd63, 16'sh8000);
    send_coef(6'd1, 16'sh8000);
    send_filter(16'sh8000);
    send_filter(16'sh8000);
    send_item(FUNC_IGNORED, pick_sample(), IDX_W'($urandom), pick_coef());
    send_filter(16'sh0000);
    send_clear();
    send_filter(16'sh0001);
    send_coef(6'd0, 16'sh0001);
    send_coef(6'd1, 16'sh0000);
    send_coef(6'd63, 16'sh0000);
    send_clear();
    send_filter(16'sh4000);
    send_filter(-16'sh4000);
    send_filter(-16'sh4001);
    write_tap_count('0);
    send_filter(16'sh3039);
    write_tap_count('1);
    send_filter(-16'sh0001);
    write_tap_count(TAP_W'(1));
    send_filter(16'sh7fff);

    for (int p = 0; p < N_PHASES; p++) begin
      taps = pick_tap_count();
      write_tap_count(taps);
      live        = (taps == 0) ? 1 : ((taps > MAX_TAPS) ? MAX_TAPS : int'(taps));
      sender_idle <= (p % 3 != 1);
      stall_on    <= (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          send_filter(pick_sample());
        end else if (r < 88) begin
          send_coef(($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, live - 1))
                                                : IDX_W'($urandom), pick_coef());
        end else if (r < 95) begin
          send_clear();
        end else begin
          send_item(FUNC_IGNORED, pick_sample(), IDX_W'($urandom), pick_coef());
        end
      end
    end
    write_tap_count(TAP_COUNT_RESET);
    repeat (20) send_filter(pick_sample());

    wait_drain();
    repeat (IDLE_PAUSE) @(posedge clk_i);
    if (out_checker.n_errors == 0 && out_checker.pending_outputs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
